// ===== rtl/rbaj_pkg.sv =====
// Package for the response bulk array joiner: payload types, byte codes and phase encoding.
// No dependencies.
package rbaj_pkg;

    localparam int OUT_OFFSET_BITS  = 16;
    localparam int MAX_HEADER_CHARS = 9;
    localparam int QUEUE_DEPTH      = 3;

    localparam logic [7:0] CH_STAR   = 8'h5C;
    localparam logic [7:0] CH_DOLLAR = 8'h5B;
    localparam logic [7:0] CH_COMMA  = 8'h6B;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h25;
    localparam logic [7:0] CH_MINUS  = 8'h60;
    localparam logic [7:0] CH_PLUS   = 8'h4E;
    localparam logic [7:0] CH_DIG0   = 8'hF0;
    localparam logic [7:0] CH_DIG9   = 8'hF9;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    localparam logic [1:0] REG_OUT_CAPACITY = 2'd0;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_response;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [1:0]  status;
        logic [29:0] elems_written;
        logic [15:0] out_length;
    } out_item_t;

    typedef enum logic [7:0] {
        PH_STAR   = 8'b0000_0001,
        PH_COUNT  = 8'b0000_0010,
        PH_DOLLAR = 8'b0000_0100,
        PH_LEN    = 8'b0000_1000,
        PH_DATA   = 8'b0001_0000,
        PH_TCR    = 8'b0010_0000,
        PH_TLF    = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } phase_t;

endpackage

// ===== rtl/rbaj_front.sv =====
// Front end: byte parser that classifies each transfer and decides what it produces.
// Depends on rbaj_pkg.
module rbaj_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  rbaj_pkg::in_item_t in_item,
    input  logic [15:0]       out_capacity,
    output logic              res_valid,
    output rbaj_pkg::out_item_t res_item
);
    import rbaj_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [29:0] hval_reg, hval_next;
    logic [3:0]  hchars_reg, hchars_next;
    logic        hneg_reg, hneg_next;
    logic        hstop_reg, hstop_next;
    logic        crp_reg, crp_next;
    logic [29:0] eleft_reg, eleft_next;
    logic [29:0] edone_reg, edone_next;
    logic [OUT_OFFSET_BITS-1:0] off_reg, off_next;
    logic [29:0] dleft_reg, dleft_next;
    logic        fits_reg, fits_next;
    logic [1:0]  rcode_reg, rcode_next;

    logic [OUT_OFFSET_BITS:0] cap;
    logic [7:0] b;
    logic       emit;
    logic [7:0] ebyte;
    logic       h_end, h_long;
    logic [OUT_OFFSET_BITS-1:0] off_c;

    // header character update on the _next copies
    function automatic logic hchar(input logic [7:0] c, input logic [3:0] n_in,
                                   input logic stop_in, inout logic [29:0] v,
                                   inout logic neg, inout logic stop);
        logic [3:0] n;
        n = n_in;
        if (n > 4'(MAX_HEADER_CHARS)) return 1'b1;
        if (!stop_in) begin
            if (n == 4'd1 && c == CH_MINUS) neg = 1'b1;
            else if (n == 4'd1 && c == CH_PLUS) ;
            else if (c >= CH_DIG0 && c <= CH_DIG9)
                v = 30'((v << 3) + (v << 1) + 30'(c - CH_DIG0));
            else stop = 1'b1;
        end
        return 1'b0;
    endfunction

    always_comb
    begin
        logic [OUT_OFFSET_BITS:0] lim;
        lim = {1'b0, {OUT_OFFSET_BITS{1'b1}}};
        cap = ({1'b0, 16'(out_capacity)} < 17'(lim)) ? (OUT_OFFSET_BITS+1)'(out_capacity)
                                                      : lim;
    end

    always_comb
    begin
        logic [3:0] hc;
        b = in_item.in_byte;
        phase_next = phase_reg; hval_next = hval_reg; hchars_next = hchars_reg;
        hneg_next = hneg_reg; hstop_next = hstop_reg; crp_next = crp_reg;
        eleft_next = eleft_reg; edone_next = edone_reg; off_next = off_reg;
        dleft_next = dleft_reg; fits_next = fits_reg; rcode_next = rcode_reg;
        emit = 1'b0; ebyte = 8'd0; h_end = 1'b0; h_long = 1'b0; off_c = off_reg;
        hc = hchars_reg;
        if (phase_reg == PH_COUNT || phase_reg == PH_LEN) begin
            if (crp_reg) begin
                crp_next = 1'b0;
                if (b == CH_LF) h_end = 1'b1;
                else begin
                    hc = (hc == 4'd15) ? hc : hc + 4'd1;
                    h_long = hchar(CH_CR, hc, hstop_next, hval_next, hneg_next,
                                   hstop_next);
                end
            end
            if (!h_end && !h_long) begin
                if (b == CH_CR) crp_next = 1'b1;
                else begin
                    hc = (hc == 4'd15) ? hc : hc + 4'd1;
                    h_long = hchar(b, hc, hstop_next, hval_next, hneg_next, hstop_next);
                end
            end
            hchars_next = hc;
        end
        case (phase_reg)
            PH_STAR:
                if (b == CH_STAR)
                begin
                    phase_next = PH_COUNT; hval_next = '0; hchars_next = '0;
                    hneg_next = 1'b0; hstop_next = 1'b0; crp_next = 1'b0;
                end
                else
                begin
                    phase_next = PH_DONE; rcode_next = ST_MALFORMED;
                end
            PH_COUNT:
                if (h_long)
                begin
                    phase_next = PH_DONE; rcode_next = ST_MALFORMED;
                end
                else if (h_end)
                begin
                    if (hval_reg == '0 || hneg_reg)
                    begin
                        phase_next = PH_DONE; rcode_next = ST_EMPTY;
                    end
                    else
                    begin
                        eleft_next = hval_reg; phase_next = PH_DOLLAR;
                    end
                end
            PH_DOLLAR:
                if (b == CH_DOLLAR)
                begin
                    phase_next = PH_LEN; hval_next = '0; hchars_next = '0;
                    hneg_next = 1'b0; hstop_next = 1'b0; crp_next = 1'b0;
                end
                else
                begin
                    phase_next = PH_DONE; rcode_next = ST_MALFORMED;
                end
            PH_LEN:
                if (h_long)
                begin
                    phase_next = PH_DONE; rcode_next = ST_MALFORMED;
                end
                else if (h_end)
                begin
                    if (hneg_reg && hval_reg != '0)
                    begin
                        phase_next = PH_DONE; rcode_next = ST_MALFORMED;
                    end
                    else
                    begin
                        dleft_next = hval_reg;
                        fits_next = 1'b1;
                        if (edone_reg != '0)
                        begin
                            if (33'(off_reg) + 33'd1 >= 33'(cap)) fits_next = 1'b0;
                            else
                            begin
                                emit = 1'b1; ebyte = CH_COMMA;
                                off_c = off_reg + 1'b1;
                            end
                        end
                        off_next = off_c;
                        if (fits_next && 33'(off_c) + 33'(hval_reg) >= 33'(cap))
                            fits_next = 1'b0;
                        phase_next = (hval_reg != '0) ? PH_DATA : PH_TCR;
                    end
                end
            PH_DATA:
            begin
                if (fits_reg)
                begin
                    emit = 1'b1; ebyte = b; off_next = off_reg + 1'b1;
                end
                dleft_next = dleft_reg - 30'd1;
                if (dleft_reg == 30'd1) phase_next = PH_TCR;
            end
            PH_TCR:
                if (b == CH_CR) phase_next = PH_TLF;
                else
                begin
                    phase_next = PH_DONE; rcode_next = ST_MALFORMED;
                end
            PH_TLF:
                if (b != CH_LF)
                begin
                    phase_next = PH_DONE; rcode_next = ST_MALFORMED;
                end
                else if (!fits_reg)
                begin
                    phase_next = PH_DONE;
                    rcode_next = (edone_reg != '0) ? ST_OK : ST_EMPTY;
                end
                else
                begin
                    edone_next = edone_reg + 30'd1;
                    eleft_next = eleft_reg - 30'd1;
                    if (eleft_reg == 30'd1)
                    begin
                        phase_next = PH_DONE; rcode_next = ST_OK;
                    end
                    else phase_next = PH_DOLLAR;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_STAR; hval_reg <= '0; hchars_reg <= '0; hneg_reg <= 1'b0;
            hstop_reg <= 1'b0; crp_reg <= 1'b0; eleft_reg <= '0; edone_reg <= '0;
            off_reg <= '0; dleft_reg <= '0; fits_reg <= 1'b0; rcode_reg <= '0;
            res_valid <= 1'b0;
            res_item <= '0;
        end
        else
        begin
            res_valid <= 1'b0;
            if (in_valid)
            begin
                if (in_item.end_of_response)
                begin
                    res_valid <= 1'b1;
                    res_item.kind <= 1'b1;
                    res_item.data_byte <= '0;
                    res_item.status <= (phase_next == PH_DONE) ? rcode_next : ST_MALFORMED;
                    res_item.elems_written <= edone_next;
                    res_item.out_length <= 16'(off_next);
                    phase_reg <= PH_STAR; hval_reg <= '0; hchars_reg <= '0;
                    hneg_reg <= 1'b0; hstop_reg <= 1'b0; crp_reg <= 1'b0;
                    eleft_reg <= '0; edone_reg <= '0; off_reg <= '0; dleft_reg <= '0;
                    fits_reg <= 1'b0; rcode_reg <= '0;
                end
                else
                begin
                    res_valid <= emit;
                    res_item <= '{kind: 1'b0, data_byte: ebyte, status: 2'd0,
                                  elems_written: 30'd0, out_length: 16'd0};
                    phase_reg <= phase_next; hval_reg <= hval_next;
                    hchars_reg <= hchars_next; hneg_reg <= hneg_next;
                    hstop_reg <= hstop_next; crp_reg <= crp_next;
                    eleft_reg <= eleft_next; edone_reg <= edone_next;
                    off_reg <= off_next; dleft_reg <= dleft_next;
                    fits_reg <= fits_next; rcode_reg <= rcode_next;
                end
            end
        end
    end

    // a data byte is only produced while the element fits
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_item.end_of_response && phase_reg == PH_DATA && !fits_reg
        |=> !res_valid) else $error("data emitted for non-fitting element");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && phase_reg == PH_DONE && !in_item.end_of_response
        |=> !res_valid) else $error("output after completion");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_item.end_of_response |=> phase_reg == PH_STAR && off_reg == '0)
        else $error("parser not re-armed after end of response");
endmodule

// ===== rtl/rbaj_queue.sv =====
// Result queue between the parser and the consumer side; its almost-full flag counts the write in progress.
// Depends on rbaj_pkg.
module rbaj_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  rbaj_pkg::out_item_t wr_item,
    output logic               almost_full,
    output logic               empty,
    input  logic               rd_en,
    output rbaj_pkg::out_item_t rd_item
);
    import rbaj_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    out_item_t   mem_reg [QUEUE_DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign empty       = (cnt_reg == '0);
    // no slot left once the write now in progress has landed
    assign almost_full = ((cnt_reg + (AW+1)'(wr_en)) >= (AW+1)'(QUEUE_DEPTH));
    assign rd_item     = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wp_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (wr_en) wp_reg <= (wp_reg == AW'(QUEUE_DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd_en) rp_reg <= (rp_reg == AW'(QUEUE_DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> cnt_reg < (AW+1)'(QUEUE_DEPTH) || rd_en) else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty) else $error("queue underflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && !rd_en |=> cnt_reg == $past(cnt_reg) + 1'b1) else $error("count slip");
endmodule

// ===== rtl/resp_bulk_array_joiner.sv =====
// Response bulk array joiner top level: APB register, parser front end, result queue.
// Depends on rbaj_pkg, rbaj_front, rbaj_queue.
// Path: a result from an input transfer passes the parser register, then the queue write,
// before the queue can present it on the result ports.
// Throughput: one byte per cycle while full is low; full rises only when the three-entry result queue,
// counting the result still in flight from the parser, has no free slot.
// Reset: rst_n clears parser state and queue; out_capacity returns to 16370.
module resp_bulk_array_joiner (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  rbaj_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output rbaj_pkg::out_item_t out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import rbaj_pkg::*;

    logic [15:0] cap_reg;
    logic        res_valid;
    out_item_t   res_item;
    logic        afull;
    logic        in_xfer;

    assign pready  = 1'b1;
    assign prdata  = (paddr == {REG_OUT_CAPACITY}) ? {16'd0, cap_reg} : 32'd0;
    // One result can still be in flight from the front end; the queue counts it.
    assign full    = afull;
    assign in_xfer = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) cap_reg <= 16'd16370;
        else if (psel && penable && pwrite && paddr == REG_OUT_CAPACITY)
            cap_reg <= pwdata[15:0];
    end

    rbaj_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_xfer), .in_item(in_item),
        .out_capacity(cap_reg), .res_valid(res_valid), .res_item(res_item)
    );

    rbaj_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(res_valid), .wr_item(res_item),
        .almost_full(afull), .empty(empty), .rd_en(pop && !empty), .rd_item(out_item)
    );
endmodule
